### sv/tpn_pkg.sv
// Shared types and constants for the tour planner.
// No dependencies; every other file except tpn_ram refers to this package by scoped names.
package tpn_pkg;

  localparam int MAX_TARGETS = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int MAX_PASSES  = 64;
  localparam int PASS_W      = 8;
  localparam int COORD_W     = 16;
  localparam int DIST_W      = 21;
  localparam int RAD_W       = 42;
  localparam int REM_W       = 24;
  localparam int ROOT_STEPS  = 21;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic                      is_cleared;
    logic                      last_target;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] target_index;
    logic             route_last;
  } out_req_t;

  // one stored target: load-order index plus coordinates
  typedef struct packed {
    logic [IDX_W-1:0]          src;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } coord_ent_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] len;
  } dist_res_t;

endpackage

### sv/tpn_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module tpn_ram #(
  parameter int W  = 8,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [W-1:0]  rdata_a,
  output logic [W-1:0]  rdata_b
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### sv/tpn_dist.sv
// Distance unit: floor(sqrt((dx^2+dy^2)*256)), squares then a bit-pair
// iterative square root. Depends on tpn_pkg.
module tpn_dist (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [tpn_pkg::COORD_W-1:0] ax,
  input  logic signed [tpn_pkg::COORD_W-1:0] ay,
  input  logic signed [tpn_pkg::COORD_W-1:0] bx,
  input  logic signed [tpn_pkg::COORD_W-1:0] by,
  output tpn_pkg::dist_res_t                res
);

  typedef enum logic [1:0] {D_IDLE, D_SQ, D_SUM, D_ROOT} phase_t;

  phase_t                          phase;
  logic [tpn_pkg::COORD_W-1:0]     adx, ady;
  logic [2*tpn_pkg::COORD_W-1:0]   sqx, sqy;
  logic [tpn_pkg::RAD_W-1:0]       rad;
  logic [tpn_pkg::REM_W-1:0]       rem;
  logic [tpn_pkg::DIST_W-1:0]      root;
  logic [4:0]                      cnt;
  logic                            done;

  logic signed [tpn_pkg::COORD_W:0] dx, dy, ndx, ndy;
  logic [2*tpn_pkg::COORD_W:0]      sum;
  logic [tpn_pkg::REM_W-1:0]        rem_s, trial;

  always_comb begin
    dx    = {ax[tpn_pkg::COORD_W-1], ax} - {bx[tpn_pkg::COORD_W-1], bx};
    dy    = {ay[tpn_pkg::COORD_W-1], ay} - {by[tpn_pkg::COORD_W-1], by};
    ndx   = -dx;
    ndy   = -dy;
    sum   = {1'b0, sqx} + {1'b0, sqy};
    rem_s = {rem[tpn_pkg::REM_W-3:0], rad[tpn_pkg::RAD_W-1 -: 2]};
    trial = {1'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == D_ROOT) && (cnt == 5'(tpn_pkg::ROOT_STEPS - 1));
      case (phase)
        D_IDLE: begin
          if (start) begin
            adx   <= dx[tpn_pkg::COORD_W] ? ndx[tpn_pkg::COORD_W-1:0] : dx[tpn_pkg::COORD_W-1:0];
            ady   <= dy[tpn_pkg::COORD_W] ? ndy[tpn_pkg::COORD_W-1:0] : dy[tpn_pkg::COORD_W-1:0];
            phase <= D_SQ;
          end
        end
        D_SQ: begin
          sqx   <= adx * adx;
          sqy   <= ady * ady;
          phase <= D_SUM;
        end
        D_SUM: begin
          rad   <= {1'b0, sum, 8'd0};
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          phase <= D_ROOT;
        end
        D_ROOT: begin
          if (rem_s >= trial) begin
            rem  <= rem_s - trial;
            root <= {root[tpn_pkg::DIST_W-2:0], 1'b1};
          end else begin
            rem  <= rem_s;
            root <= {root[tpn_pkg::DIST_W-2:0], 1'b0};
          end
          rad <= {rad[tpn_pkg::RAD_W-3:0], 2'b00};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(tpn_pkg::ROOT_STEPS - 1)) begin
            phase <= D_IDLE;
          end
        end
        default: phase <= D_IDLE;
      endcase
    end
  end

  assign res.done = done;
  assign res.len  = root;

endmodule

### sv/tour_planner_nn_two_opt.sv
// Tour planner top: loads targets one per cycle, then plans a nearest
// neighbour tour improved by 2-opt and streams it out as load indices.
// Loading: one request per cycle; stall stays high from the last target until
// the final route index is taken, or until planning finds no kept target.
// Planning takes O(n^2) distance evaluations per NN build and per 2-opt pass,
// all in the shared sqrt unit. Synchronous active-high reset returns to loading.
module tour_planner_nn_two_opt (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tpn_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output tpn_pkg::out_req_t out_req
);

  typedef enum logic [4:0] {
    S_LOAD, S_PLAN, S_SMALL, S_NN_INIT, S_NN_K, S_NN_I, S_NN_CMP,
    S_DIST_RD, S_DIST_GO, S_DIST_WAIT, S_TRD,
    S_OPT_PASS, S_OPT_I, S_OPT_J, S_OPT_RD1, S_OPT_RD2,
    S_OPT_D1, S_OPT_D2, S_OPT_D3, S_OPT_D4, S_OPT_CMP,
    S_REV, S_REV_W1, S_REV_W2, S_PASS_END,
    S_OUT_RD, S_OUT_SRC, S_OUT_LAT, S_OUT_SET, S_OUT_EMIT
  } state_t;

  localparam int IW = tpn_pkg::IDX_W;
  localparam int CW = tpn_pkg::CNT_W;
  localparam int DW = tpn_pkg::DIST_W;

  state_t                    state, ret;
  logic [CW-1:0]             loaded_count, kept_count, n, k, i, j, lo, hi;
  logic [tpn_pkg::PASS_W-1:0] pass_count;
  logic [tpn_pkg::MAX_TARGETS-1:0] visited;
  logic                      gain, found;
  logic [IW-1:0]             cur, best, tim, ti, tj, tj1, hold_a;
  logic [DW-1:0]             bd, dval, sa;
  logic [DW:0]               sb;
  logic [IW-1:0]             ca, cb, ta, tb;
  logic                      twe;
  logic [IW-1:0]             twaddr, twdata;

  tpn_pkg::coord_ent_t       cwdata, cqa, cqb;
  logic                      cwe, in_acc;
  logic [IW-1:0]             tqa, tqb;
  tpn_pkg::dist_res_t        dres;
  logic [CW-1:0]             kept_next, im1;

  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign cwe      = in_acc && (loaded_count < CW'(tpn_pkg::MAX_TARGETS))
                    && !in_req.is_cleared;
  assign cwdata   = '{src: loaded_count[IW-1:0], x: in_req.pos_x, y: in_req.pos_y};
  assign kept_next = cwe ? kept_count + CW'(1) : kept_count;
  assign im1       = i - CW'(1);

  tpn_ram #(.W($bits(tpn_pkg::coord_ent_t)), .AW(IW)) u_cmem (
    .clk(clk), .we(cwe), .waddr(kept_count[IW-1:0]), .wdata(cwdata),
    .raddr_a(ca), .raddr_b(cb), .rdata_a(cqa), .rdata_b(cqb)
  );

  tpn_ram #(.W(IW), .AW(IW)) u_tmem (
    .clk(clk), .we(twe), .waddr(twaddr), .wdata(twdata),
    .raddr_a(ta), .raddr_b(tb), .rdata_a(tqa), .rdata_b(tqb)
  );

  tpn_dist u_dist (
    .clk(clk), .rst(rst), .start(state == S_DIST_GO),
    .ax(cqa.x), .ay(cqa.y), .bx(cqb.x), .by(cqb.y), .res(dres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      loaded_count <= '0;
      kept_count   <= '0;
      out_valid    <= 1'b0;
      twe          <= 1'b0;
      pass_count   <= '0;
    end else begin
      // tour writes: small-set fill, NN start and pick, swap halves
      twe <= (state inside {S_SMALL, S_NN_INIT, S_REV_W1, S_REV_W2})
             || (state == S_NN_I && i == n);
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (in_req.last_target) begin
              n            <= kept_next;
              loaded_count <= '0;
              kept_count   <= '0;
              state        <= S_PLAN;
            end else if (loaded_count < CW'(tpn_pkg::MAX_TARGETS)) begin
              loaded_count <= loaded_count + CW'(1);
              kept_count   <= kept_next;
            end
          end
        end
        S_PLAN: begin
          k <= '0;
          if (n == '0) state <= S_LOAD;
          else if (n < CW'(3)) state <= S_SMALL;
          else state <= S_NN_INIT;
        end
        S_SMALL: begin
          twaddr <= k[IW-1:0];
          twdata <= k[IW-1:0];
          if (k + CW'(1) == n) begin
            k     <= '0;
            state <= S_OUT_RD;
          end else begin
            k <= k + CW'(1);
          end
        end
        S_NN_INIT: begin
          visited    <= tpn_pkg::MAX_TARGETS'(1);
          twaddr     <= '0;
          twdata     <= '0;
          cur        <= '0;
          k          <= CW'(1);
          state      <= S_NN_K;
        end
        S_NN_K: begin
          i     <= '0;
          found <= 1'b0;
          state <= S_NN_I;
        end
        S_NN_I: begin
          if (i == n) begin
            twaddr        <= k[IW-1:0];
            twdata        <= best;
            visited[best] <= 1'b1;
            cur           <= best;
            if (k + CW'(1) == n) begin
              pass_count <= '0;
              state      <= S_OPT_PASS;
            end else begin
              k     <= k + CW'(1);
              state <= S_NN_K;
            end
          end else if (visited[i[IW-1:0]]) begin
            i <= i + CW'(1);
          end else begin
            ca    <= cur;
            cb    <= i[IW-1:0];
            ret   <= S_NN_CMP;
            state <= S_DIST_RD;
          end
        end
        S_NN_CMP: begin
          // strict compare keeps the lower index on ties
          if (!found || dval < bd) begin
            bd    <= dval;
            best  <= i[IW-1:0];
            found <= 1'b1;
          end
          i     <= i + CW'(1);
          state <= S_NN_I;
        end
        S_DIST_RD:   state <= S_DIST_GO;
        S_DIST_GO:   state <= S_DIST_WAIT;
        S_DIST_WAIT: begin
          if (dres.done) begin
            dval  <= dres.len;
            state <= ret;
          end
        end
        S_TRD: state <= ret;
        S_OPT_PASS: begin
          gain  <= 1'b0;
          i     <= CW'(1);
          state <= S_OPT_I;
        end
        S_OPT_I: begin
          if (i + CW'(2) < n) begin
            j     <= i + CW'(1);
            state <= S_OPT_J;
          end else begin
            state <= S_PASS_END;
          end
        end
        S_OPT_J: begin
          if (j + CW'(1) < n) begin
            ta    <= im1[IW-1:0];
            tb    <= i[IW-1:0];
            ret   <= S_OPT_RD1;
            state <= S_TRD;
          end else begin
            i     <= i + CW'(1);
            state <= S_OPT_I;
          end
        end
        S_OPT_RD1: begin
          tim   <= tqa;
          ti    <= tqb;
          ta    <= j[IW-1:0];
          tb    <= IW'(j + CW'(1));
          ret   <= S_OPT_RD2;
          state <= S_TRD;
        end
        S_OPT_RD2: begin
          tj    <= tqa;
          tj1   <= tqb;
          state <= S_OPT_D1;
        end
        S_OPT_D1: begin
          ca <= tim; cb <= ti; ret <= S_OPT_D2; state <= S_DIST_RD;
        end
        S_OPT_D2: begin
          sb <= {1'b0, dval};
          ca <= tj; cb <= tj1; ret <= S_OPT_D3; state <= S_DIST_RD;
        end
        S_OPT_D3: begin
          sb <= sb + {1'b0, dval};
          ca <= tim; cb <= tj; ret <= S_OPT_D4; state <= S_DIST_RD;
        end
        S_OPT_D4: begin
          sa <= dval;
          ca <= ti; cb <= tj1; ret <= S_OPT_CMP; state <= S_DIST_RD;
        end
        S_OPT_CMP: begin
          // dval now holds the fourth distance
          if (({1'b0, sa} + {1'b0, dval}) < sb) begin
            lo    <= i;
            hi    <= j;
            state <= S_REV;
          end else begin
            j     <= j + CW'(1);
            state <= S_OPT_J;
          end
        end
        S_REV: begin
          if (lo < hi) begin
            ta    <= lo[IW-1:0];
            tb    <= hi[IW-1:0];
            ret   <= S_REV_W1;
            state <= S_TRD;
          end else begin
            gain  <= 1'b1;
            j     <= j + CW'(1);
            state <= S_OPT_J;
          end
        end
        S_REV_W1: begin
          twaddr <= lo[IW-1:0];
          twdata <= tqb;
          hold_a <= tqa;
          state  <= S_REV_W2;
        end
        S_REV_W2: begin
          twaddr <= hi[IW-1:0];
          twdata <= hold_a;
          lo     <= lo + CW'(1);
          hi     <= hi - CW'(1);
          state  <= S_REV;
        end
        S_PASS_END: begin
          pass_count <= pass_count + tpn_pkg::PASS_W'(1);
          if (gain && (pass_count + tpn_pkg::PASS_W'(1))
                      < tpn_pkg::PASS_W'(tpn_pkg::MAX_PASSES)) begin
            state <= S_OPT_PASS;
          end else begin
            k     <= '0;
            state <= S_OUT_RD;
          end
        end
        S_OUT_RD: begin
          ta    <= k[IW-1:0];
          ret   <= S_OUT_SRC;
          state <= S_TRD;
        end
        S_OUT_SRC: begin
          ca    <= tqa;
          state <= S_OUT_LAT;
        end
        S_OUT_LAT: state <= S_OUT_SET;
        S_OUT_SET: begin
          out_req.target_index <= cqa.src;
          out_req.route_last   <= (k + CW'(1) == n);
          out_valid            <= 1'b1;
          state                <= S_OUT_EMIT;
        end
        S_OUT_EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (k + CW'(1) == n) begin
              state <= S_LOAD;
            end else begin
              k     <= k + CW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

### sv/tpn_checker.sv
// Port-level checks for the tour planner, bound to the top level.
// Depends on tpn_pkg and tour_planner_nn_two_opt.
module tpn_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input tpn_pkg::in_req_t  in_req,
  input logic              out_valid,
  input logic              out_stall,
  input tpn_pkg::out_req_t out_req
);

  // route is only shown while loading is held off
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("output while loading");

  // the last target starts planning
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_req.last_target) |=> in_stall)
    else $error("no stall after last target");

  // nothing follows the final route index
  a_route_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_req.route_last) |=> !out_valid)
    else $error("result after route end");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_req)))
    else $error("stalled output changed");

endmodule

bind tour_planner_nn_two_opt tpn_checker u_tpn_checker (.*);

### test/tb_top.sv
// Testbench for the tour planner: loads target sets, predicts each planned
// route (nearest neighbour plus 2-opt) and checks the streamed indices.
// Depends on tpn_pkg and tour_planner_nn_two_opt.
module tb_top;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  tpn_pkg::in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tpn_pkg::out_req_t out_req;

  tour_planner_nn_two_opt dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_req(in_req), .out_valid(out_valid), .out_stall(out_stall), .out_req(out_req)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  longint sx[tpn_pkg::MAX_TARGETS];
  longint sy[tpn_pkg::MAX_TARGETS];
  int src_idx[tpn_pkg::MAX_TARGETS];
  int route[tpn_pkg::MAX_TARGETS];
  int n_loaded = 0;
  int n_kept = 0;
  tpn_pkg::out_req_t route_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned hop(int a, int b);
    longint dx, dy;
    longint unsigned ux, uy;
    dx = sx[a] - sx[b];
    dy = sy[a] - sy[b];
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    return root_floor((ux * ux + uy * uy) * 256);
  endfunction

  task automatic plan_route();
    bit seen[tpn_pkg::MAX_TARGETS];
    int n, k, i, j, lo, hi, t, cur, best, passes;
    bit found, gain;
    longint unsigned bd, d, was, now;
    tpn_pkg::out_req_t exp_r;
    n = n_kept;
    foreach (seen[m]) seen[m] = 1'b0;
    if (n < 3) begin
      for (i = 0; i < n; i++) route[i] = i;
    end else begin
      route[0] = 0;
      seen[0] = 1'b1;
      for (k = 1; k < n; k++) begin
        cur = route[k-1];
        found = 1'b0;
        best = 0;
        bd = 0;
        for (i = 0; i < n; i++) begin
          if (!seen[i]) begin
            d = hop(cur, i);
            if (!found || d < bd) begin
              bd = d;
              best = i;
              found = 1'b1;
            end
          end
        end
        route[k] = best;
        seen[best] = 1'b1;
      end
      passes = 0;
      do begin
        gain = 1'b0;
        for (i = 1; i + 2 < n; i++) begin
          for (j = i + 1; j + 1 < n; j++) begin
            was = hop(route[i-1], route[i]) + hop(route[j], route[j+1]);
            now = hop(route[i-1], route[j]) + hop(route[i], route[j+1]);
            if (now < was) begin
              lo = i;
              hi = j;
              while (lo < hi) begin
                t = route[lo];
                route[lo] = route[hi];
                route[hi] = t;
                lo++;
                hi--;
              end
              gain = 1'b1;
            end
          end
        end
        passes++;
      end while (gain && passes < tpn_pkg::MAX_PASSES);
    end
    for (i = 0; i < n; i++) begin
      exp_r.target_index = src_idx[route[i]][tpn_pkg::IDX_W-1:0];
      exp_r.route_last = (i + 1 == n);
      route_q = {route_q, exp_r};
    end
  endtask

  task automatic predict_load(tpn_pkg::in_req_t r);
    if (n_loaded < tpn_pkg::MAX_TARGETS) begin
      if (!r.is_cleared && n_kept < tpn_pkg::MAX_TARGETS) begin
        sx[n_kept] = r.pos_x;
        sy[n_kept] = r.pos_y;
        src_idx[n_kept] = n_loaded;
        n_kept++;
      end
      n_loaded++;
    end
    if (r.last_target) begin
      plan_route();
      n_loaded = 0;
      n_kept = 0;
    end
  endtask

  // route check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (route_q.size() == 0) begin
          $error("route index %0d with nothing expected", out_req.target_index);
          errors++;
        end else begin
          if (out_req.target_index !== route_q[0].target_index) begin
            $error("target_index expected %0d got %0d", route_q[0].target_index,
                   out_req.target_index);
            errors++;
          end
          if (out_req.route_last !== route_q[0].route_last) begin
            $error("route_last expected %0d got %0d", route_q[0].route_last,
                   out_req.route_last);
            errors++;
          end
          void'(route_q.pop_front());
        end
      end
    end
  end

  // worst set: 64 targets, 64 passes of ~1900 pair checks
  always @(posedge clk) begin
    if (idle_cycles >= 50000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // one request; sender idles at random before offering it
  task automatic send_target(tpn_pkg::in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_load(r);
  endtask

  function automatic tpn_pkg::in_req_t rand_target(bit last, bit clustered);
    tpn_pkg::in_req_t r;
    if (clustered) begin
      r.pos_x = 16'(int'($urandom_range(200)) - 100);
      r.pos_y = 16'(int'($urandom_range(200)) - 100);
    end else begin
      r.pos_x = 16'($urandom);
      r.pos_y = 16'($urandom);
    end
    r.is_cleared = ($urandom_range(5) == 0);
    r.last_target = last;
    return r;
  endfunction

  task automatic send_set(int len);
    bit cl;
    cl = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) send_target(rand_target(i == len - 1, cl));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (route_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // directed rows: x, y, cleared, last, expected first index (-1: predictor only)
  typedef struct {
    int x;
    int y;
    bit clr;
    bit last;
    int first_idx;
  } row_t;

  row_t rows[] = '{
    '{-32768, -32768, 1'b0, 1'b1, 0},   // single target
    '{32767, 32767, 1'b1, 1'b1, -1},    // all cleared: no route
    '{5, 5, 1'b1, 1'b0, -1},
    '{32767, -32768, 1'b0, 1'b0, -1},   // two kept: index order
    '{-32768, 32767, 1'b0, 1'b1, 1},
    '{0, 0, 1'b0, 1'b0, -1},            // tie on distance goes to lower index
    '{10, 0, 1'b0, 1'b0, -1},
    '{-10, 0, 1'b0, 1'b0, -1},
    '{0, 10, 1'b1, 1'b0, -1},
    '{0, 20, 1'b0, 1'b1, 0},
    '{0, 0, 1'b0, 1'b0, -1},            // crossing path that 2-opt untangles
    '{100, 100, 1'b0, 1'b0, -1},
    '{100, 0, 1'b0, 1'b0, -1},
    '{0, 100, 1'b0, 1'b0, -1},
    '{-32768, 32767, 1'b0, 1'b0, -1},
    '{32767, -32768, 1'b0, 1'b1, 0}
  };

  initial begin
    tpn_pkg::in_req_t r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      r.pos_x = 16'(rows[i].x);
      r.pos_y = 16'(rows[i].y);
      r.is_cleared = rows[i].clr;
      r.last_target = rows[i].last;
      if (rows[i].first_idx >= 0) begin
        send_target(r);
        if (route_q.size() != 0 && rows[i].last &&
            route_q[0].target_index != rows[i].first_idx) begin
          $error("target_index expected %0d got %0d", rows[i].first_idx,
                 route_q[0].target_index);
          errors++;
        end
      end else begin
        send_target(r);
      end
    end
    drain();

    // beyond capacity: 70 items, the last 6 ignored but the marker plans
    for (int i = 0; i < 70; i++) begin
      r = rand_target(i == 69, 1'b1);
      r.is_cleared = (i % 9 == 0);
      send_target(r);
    end
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;  repeat (4) send_set($urandom_range(3, 8));
    send_idle_pct = 79; recv_stall_pct = 0;  repeat (6) send_set($urandom_range(1, 8));
    send_idle_pct = 0;  recv_stall_pct = 79; repeat (6) send_set($urandom_range(1, 8));
    send_idle_pct = 15; recv_stall_pct = 15; repeat (6) send_set($urandom_range(3, 10));
    drain();

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;  recv_stall_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (3000) @(posedge clk);
        hold_recv = 1'b0;
      end
      repeat (2) send_set($urandom_range(4, 8));
    join
    drain();

    recv_stall_pct = 15;
    repeat (2) send_set($urandom_range(3, 12));
    drain();

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
